@@ sv/mkd_pkg.sv @@
// Package for the Morse key decoder: request and event codes, register
// indexes, reset values, limits and the tree-index to ASCII lookup.
// No dependencies.
`default_nettype none

package mkd_pkg;

    localparam int MKD_MAX_SYMBOLS = 9;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int MIN_PRESS_W = 8;
    localparam int DASH_W      = 16;
    localparam int SLEEP_W     = 15;
    localparam int HOLD_W      = 16;
    localparam int IDLE_W      = 15;
    localparam int COUNT_W     = 4;
    localparam int INDEX_W     = 10;
    localparam int CHAR_W      = 7;
    localparam int ROM_ADDR_W  = 6;

    localparam logic [MIN_PRESS_W-1:0] MIN_PRESS_RESET = 8'd2;
    localparam logic [DASH_W-1:0]      DASH_RESET      = 16'd30;
    localparam logic [SLEEP_W-1:0]     SLEEP_RESET     = 15'd3000;
    localparam logic [IDLE_W-1:0]      IDLE_LIMIT      = 15'd32000;
    localparam logic [HOLD_W-1:0]      HOLD_LIMIT      = 16'hFFFF;
    localparam logic [CHAR_W-1:0]      BAD_CHAR        = 7'h3F;
    localparam logic [CHAR_W-1:0]      NO_CHAR         = 7'h00;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_COMMIT = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DOT  = 2'd1,
        EV_DASH = 2'd2
    } t_event;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MIN_PRESS = 2'd0,
        CFG_DASH_THR  = 2'd1,
        CFG_SLEEP_TO  = 2'd2
    } t_cfg_reg;

    // Heap-ordered tree: index 1 is the root, left child is a dot.
    function automatic logic [CHAR_W-1:0] tree_rom(input logic [ROM_ADDR_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            6'd2:  c = "E";  6'd3:  c = "T";  6'd4:  c = "I";  6'd5:  c = "A";
            6'd6:  c = "N";  6'd7:  c = "M";  6'd8:  c = "S";  6'd9:  c = "U";
            6'd10: c = "R";  6'd11: c = "W";  6'd12: c = "D";  6'd13: c = "K";
            6'd14: c = "G";  6'd15: c = "O";  6'd16: c = "H";  6'd17: c = "V";
            6'd18: c = "F";  6'd20: c = "L";  6'd22: c = "P";  6'd23: c = "J";
            6'd24: c = "B";  6'd25: c = "X";  6'd26: c = "C";  6'd27: c = "Y";
            6'd28: c = "Z";  6'd29: c = "Q";  6'd32: c = "5";  6'd33: c = "4";
            6'd35: c = "3";  6'd39: c = "2";  6'd47: c = "1";  6'd48: c = "6";
            6'd56: c = "7";  6'd60: c = "8";  6'd62: c = "9";  6'd63: c = "0";
            default: c = 8'd0;
        endcase
        return c[CHAR_W-1:0];
    endfunction

    // empty: no symbols held; beyond: index past the ROM.
    function automatic logic [CHAR_W-1:0] decode_code(input logic empty,
                                                      input logic beyond,
                                                      input logic [ROM_ADDR_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        c = tree_rom(idx);
        if (empty) begin
            return NO_CHAR;
        end else if (beyond || c == NO_CHAR) begin
            return BAD_CHAR;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/morse_key_decoder.sv @@
// Morse key decoder top level: key timing, symbol tree index, letter decode.
// Depends on mkd_pkg.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) carries one request per transaction:
//   a tick with a key sample, a letter commit, a delete of the last symbol or a no-op.
//   Output channel (o_out_valid/i_out_ready) returns exactly one result per
//   request, in order.
//   Config port writes min_press, dash_threshold and the sleep idle limit by
//   index on any edge with i_cfg_we high; write only while no result is pending.
// Timing:
//   A request accepted at edge N has its result held in the output register
//   from edge N. Throughput is one request per cycle while i_out_ready
//   does not stall the output; the state update and both tree ROM lookups
//   fit in the single pass between accept and the output register.
// Reset (synchronous, active low): config takes its reset values, the code
//   is emptied (index 1), counters clear, no result is pending.
// Stall: while i_out_ready is low and a result is held, o_in_ready is low
//   and the held result stays unchanged; o_in_ready follows i_out_ready once
//   the output register is full.
`default_nettype none

module morse_key_decoder
    import mkd_pkg::*;
#(
    parameter int MAX_SYMBOLS = MKD_MAX_SYMBOLS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_req_type,
    input  wire logic                  i_key_down,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_key_drive,
    output logic [1:0]                 o_symbol_event,
    output logic [COUNT_W-1:0]         o_symbol_count,
    output logic [INDEX_W-1:0]         o_code_index,
    output logic [CHAR_W-1:0]          o_preview_char,
    output logic                       o_letter_valid,
    output logic [CHAR_W-1:0]          o_letter,
    output logic                       o_sleep_request
);

    localparam int                 TREE_W  = MAX_SYMBOLS + 1;
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SYMBOLS);
    localparam logic [TREE_W-1:0]  ROOT    = TREE_W'(1);

    logic [MIN_PRESS_W-1:0] r_min_press;
    logic [DASH_W-1:0]      r_dash_thr;
    logic [SLEEP_W-1:0]     r_sleep_to;

    logic [HOLD_W-1:0]  r_hold,     n_hold;
    logic               r_was_down, n_was_down;
    logic [IDLE_W-1:0]  r_idle,     n_idle;
    logic [COUNT_W-1:0] r_total,    n_total;
    logic [TREE_W-1:0]  r_tree,     n_tree;

    logic               r_out_valid;
    logic               r_key_drive,  n_key_drive;
    t_event             r_event,      n_event;
    logic [COUNT_W-1:0] r_count;
    logic [INDEX_W-1:0] r_index;
    logic [CHAR_W-1:0]  r_preview,    n_preview;
    logic               r_letter_vld, n_letter_vld;
    logic [CHAR_W-1:0]  r_letter,     n_letter;
    logic               r_sleep,      n_sleep;

    logic               in_acc;
    logic               dash;
    logic [CHAR_W-1:0]  cur_char;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_press <= MIN_PRESS_RESET;
            r_dash_thr  <= DASH_RESET;
            r_sleep_to  <= SLEEP_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_MIN_PRESS: r_min_press <= i_cfg_wdata[MIN_PRESS_W-1:0];
                CFG_DASH_THR:  r_dash_thr  <= i_cfg_wdata[DASH_W-1:0];
                CFG_SLEEP_TO:  r_sleep_to  <= i_cfg_wdata[SLEEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign dash     = r_hold >= r_dash_thr;
    assign cur_char = decode_code(r_total == '0, (r_tree >> ROM_ADDR_W) != '0,
                                  r_tree[ROM_ADDR_W-1:0]);

    always_comb begin
        n_hold       = r_hold;
        n_was_down   = r_was_down;
        n_idle       = r_idle;
        n_total      = r_total;
        n_tree       = r_tree;
        n_key_drive  = 1'b0;
        n_event      = EV_NONE;
        n_letter_vld = 1'b0;
        n_letter     = NO_CHAR;
        unique case (t_req'(i_req_type))
            REQ_TICK: begin
                n_key_drive = i_key_down;
                n_was_down  = i_key_down;
                if (i_key_down) begin
                    n_idle = '0;
                    if (r_hold != HOLD_LIMIT) begin
                        n_hold = r_hold + 1'b1;
                    end
                end else if (r_was_down) begin
                    n_idle = '0;
                    n_hold = '0;
                    if (r_hold > HOLD_W'(r_min_press) && r_total < MAX_CNT) begin
                        n_tree  = {r_tree[TREE_W-2:0], dash};
                        n_total = r_total + 1'b1;
                        n_event = dash ? EV_DASH : EV_DOT;
                    end
                end else if (r_idle < IDLE_LIMIT) begin
                    n_idle = r_idle + 1'b1;
                end
            end
            REQ_COMMIT: begin
                n_idle = '0;
                if (r_total != '0) begin
                    if (cur_char != BAD_CHAR) begin
                        n_letter_vld = 1'b1;
                        n_letter     = cur_char;
                    end
                    n_total = '0;
                    n_tree  = ROOT;
                end
            end
            REQ_DELETE: begin
                n_idle = '0;
                if (r_total != '0) begin
                    n_total = r_total - 1'b1;
                    n_tree  = r_tree >> 1;
                end
            end
            default: ;
        endcase
        n_preview = decode_code(n_total == '0, (n_tree >> ROM_ADDR_W) != '0,
                                n_tree[ROM_ADDR_W-1:0]);
        n_sleep   = n_idle > r_sleep_to;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold      <= '0;
            r_was_down  <= 1'b0;
            r_idle      <= '0;
            r_total     <= '0;
            r_tree      <= ROOT;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_hold      <= n_hold;
                r_was_down  <= n_was_down;
                r_idle      <= n_idle;
                r_total     <= n_total;
                r_tree      <= n_tree;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_key_drive  <= n_key_drive;
            r_event      <= n_event;
            r_count      <= n_total;
            r_index      <= INDEX_W'(n_tree);
            r_preview    <= n_preview;
            r_letter_vld <= n_letter_vld;
            r_letter     <= n_letter;
            r_sleep      <= n_sleep;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_key_drive     = r_key_drive;
    assign o_symbol_event  = r_event;
    assign o_symbol_count  = r_count;
    assign o_code_index    = r_index;
    assign o_preview_char  = r_preview;
    assign o_letter_valid  = r_letter_vld;
    assign o_letter        = r_letter;
    assign o_sleep_request = r_sleep;

endmodule

`default_nettype wire

@@ sv/mkd_checker.sv @@
// Port-level checker for the Morse key decoder, bound to the top level.
// Depends on mkd_pkg and morse_key_decoder.
`default_nettype none

module mkd_checker
    import mkd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire logic                  o_key_drive,
    input wire logic [1:0]            o_symbol_event,
    input wire logic [COUNT_W-1:0]    o_symbol_count,
    input wire logic [INDEX_W-1:0]    o_code_index,
    input wire logic [CHAR_W-1:0]     o_preview_char,
    input wire logic                  o_letter_valid,
    input wire logic [CHAR_W-1:0]     o_letter,
    input wire logic                  o_sleep_request
);

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_letter)
            && $stable(o_code_index) && $stable(o_symbol_count))
        else $error("result changed while stalled");

    a_letter_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_letter_valid |-> o_letter != BAD_CHAR && o_letter != NO_CHAR
            && o_symbol_count == '0 && o_code_index == INDEX_W'(1))
        else $error("committed letter invalid or code not cleared");

    a_empty_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_symbol_count == '0 |->
            o_code_index == INDEX_W'(1) && o_preview_char == NO_CHAR)
        else $error("empty code shows index or preview");

    a_symbol_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_symbol_event == EV_DOT || o_symbol_event == EV_DASH) |->
            o_code_index[0] == (o_symbol_event == EV_DASH) && o_symbol_count != '0
            && o_letter_valid == 1'b0)
        else $error("appended symbol not reflected in index");

    a_key_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_drive |->
            o_symbol_event == EV_NONE && !o_sleep_request)
        else $error("key down tick appended a symbol or requested sleep");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (.*);

`default_nettype wire
